// File: design/dda_pkg.sv
// Shared types and constants of the DDA line rasterizer.
package dda_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_NEXT  = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   mode;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pixel_t;

endpackage

// File: design/dda_div.sv
// Serial restoring divider that gives round(num * 2^FRAC_BITS / den), one quotient bit a cycle.
module dda_div #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  dda_pkg::coord_t               num,
    input  dda_pkg::coord_t               den,
    output logic                          done,
    output logic [FRAC_BITS:0]            quo
);

    localparam int C  = dda_pkg::COORD_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(QW);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_RUN   = 2'd1;
    localparam logic [1:0] D_ROUND = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    logic [C-1:0]  rem_reg, rem_next;
    logic [QW-1:0] bits_reg, bits_next;
    logic [C-1:0]  den_reg, den_next;
    logic [QW-1:0] q_reg, q_next;

    logic [C:0]    trial;
    logic [C:0]    diff;
    logic          ge;
    logic          round_up;

    assign trial    = {rem_reg, bits_reg[QW-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = trial >= {1'b0, den_reg};
    assign round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    rem_next   = {1'b0, num[C-1:1]};
                    bits_next  = {num[0], {FRAC_BITS{1'b0}}};
                    den_next   = den;
                    q_next     = '0;
                    cnt_next   = CW'(QW - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next  = ge ? diff[C-1:0] : trial[C-1:0];
                bits_next = {bits_reg[QW-2:0], 1'b0};
                q_next    = {q_reg[QW-2:0], ge};
                if (cnt_reg == '0)
                begin
                    state_next = D_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            D_ROUND:
            begin
                q_next     = q_reg + QW'(round_up);
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// File: design/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: line setup sequencer, position stepping and output register.
//
// A start transaction sets up a new line and yields its first pixel; the serial divider computes
// the x and then the y increment one quotient bit per cycle. A start with equal endpoints skips
// the divider. A next transaction steps the position and then rounds it into the output register.
// A next transaction with no line in progress yields no pixel. The input stalls while an item is
// in work; a finished pixel waits in the output register while the next item is accepted.
module dda_line_rasterizer #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  dda_pkg::item_t  item,
    output logic            pixel_valid,
    input  logic            pixel_stall,
    output dda_pkg::pixel_t pixel
);

    localparam int C  = dda_pkg::COORD_BITS;
    localparam int PW = C + FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 1;
    localparam int IW = FRAC_BITS + 2;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_STEPS = 3'd2;
    localparam logic [2:0] S_DIVX  = 3'd3;
    localparam logic [2:0] S_DIVY  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              active_reg, active_next;
    logic              out_valid_reg, out_valid_next;

    dda_pkg::coord_t   x0_reg, x0_next, y0_reg, y0_next;
    dda_pkg::coord_t   x1_reg, x1_next, y1_reg, y1_next;
    logic [C-1:0]      ax_reg, ax_next, ay_reg, ay_next;
    logic              sx_reg, sx_next, sy_reg, sy_next;
    logic [C-1:0]      steps_reg, steps_next;
    logic [PW-1:0]     xpos_reg, xpos_next, ypos_reg, ypos_next;
    logic [IW-1:0]     xinc_reg, xinc_next, yinc_reg, yinc_next;
    logic              last_reg, last_next;
    dda_pkg::pixel_t   out_reg, out_next;

    logic              accept;
    logic              out_free;
    logic [C:0]        dx, dy;
    logic [C:0]        dx_neg, dy_neg;
    logic [C-1:0]      steps_comb;
    logic [PW-1:0]     xr, yr;
    logic [IW-1:0]     q_ext;

    logic              div_start;
    dda_pkg::coord_t   div_num, div_den;
    logic              div_done;
    logic [QW-1:0]     div_q;

    dda_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_q)
    );

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !pixel_stall;

    assign dx     = {1'b0, x1_reg} - {1'b0, x0_reg};
    assign dy     = {1'b0, y1_reg} - {1'b0, y0_reg};
    assign dx_neg = -dx;
    assign dy_neg = -dy;

    assign steps_comb = (ax_reg >= ay_reg) ? ax_reg : ay_reg;
    assign q_ext      = {1'b0, div_q};

    assign xr = xpos_reg + HALF - {{(PW-1){1'b0}}, xpos_reg[PW-1]};
    assign yr = ypos_reg + HALF - {{(PW-1){1'b0}}, ypos_reg[PW-1]};

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && pixel_stall;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        steps_next     = steps_reg;
        xpos_next      = xpos_reg;
        ypos_next      = ypos_reg;
        xinc_next      = xinc_reg;
        yinc_next      = yinc_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        div_num        = ax_reg;
        div_den        = steps_comb;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode == dda_pkg::MODE_START)
                    begin
                        x0_next    = item.x_start;
                        y0_next    = item.y_start;
                        x1_next    = item.x_end;
                        y1_next    = item.y_end;
                        state_next = S_SETUP;
                    end
                    else if (active_reg)
                    begin
                        xpos_next  = xpos_reg + {{(PW-IW){xinc_reg[IW-1]}}, xinc_reg};
                        ypos_next  = ypos_reg + {{(PW-IW){yinc_reg[IW-1]}}, yinc_reg};
                        steps_next = steps_reg - 1'b1;
                        last_next  = (steps_reg == C'(1));
                        active_next = (steps_reg != C'(1));
                        state_next = S_EMIT;
                    end
                end
            end
            S_SETUP:
            begin
                sx_next    = dx[C];
                sy_next    = dy[C];
                ax_next    = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
                ay_next    = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
                state_next = S_STEPS;
            end
            S_STEPS:
            begin
                steps_next = steps_comb;
                xpos_next  = {1'b0, x0_reg, {FRAC_BITS{1'b0}}};
                ypos_next  = {1'b0, y0_reg, {FRAC_BITS{1'b0}}};
                if (steps_comb == '0)
                begin
                    xinc_next   = '0;
                    yinc_next   = '0;
                    last_next   = 1'b1;
                    active_next = 1'b0;
                    state_next  = S_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                div_num = ay_reg;
                div_den = steps_reg;
                if (div_done)
                begin
                    xinc_next  = sx_reg ? -q_ext : q_ext;
                    div_start  = 1'b1;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    yinc_next   = sy_reg ? -q_ext : q_ext;
                    last_next   = 1'b0;
                    active_next = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next.pixel_x    = xr[FRAC_BITS+C-1:FRAC_BITS];
                    out_next.pixel_y    = yr[FRAC_BITS+C-1:FRAC_BITS];
                    out_next.last_pixel = last_reg;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
            xpos_reg      <= '0;
            ypos_reg      <= '0;
            xinc_reg      <= '0;
            yinc_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            xpos_reg      <= xpos_next;
            ypos_reg      <= ypos_next;
            xinc_reg      <= xinc_next;
            yinc_reg      <= yinc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule
